// File: design/apcr_pkg.sv
// Shared types and constants for the box pair collision resolver.
// Used by apcr_geom, apcr_div and the top level.
package apcr_pkg;

  localparam int PosW  = 24;
  localparam int SizeW = 16;
  localparam int MassW = 16;
  localparam int MoveW = 17;
  localparam int PenW  = 16;
  localparam int DivW  = MassW + 1;

  typedef enum logic [1:0] {
    MV_NONE = 2'd0,
    MV_BOTH = 2'd1,
    MV_ONE1 = 2'd2,
    MV_ONE2 = 2'd3
  } move_mode_t;

  // Control travelling alongside the share division
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic            along_y;
    move_mode_t      mode;
    logic            neg;   // pos2 < pos1 on the chosen axis
    logic            zero;  // pos2 == pos1 on the chosen axis
    logic [PenW-1:0] p;
  } ctl_t;

endpackage

// File: design/aabb_pair_collision_resolve.sv
// Box pair collision resolver.
// Channels: a command port (start/busy) taking one box pair, and a result
// port marked by done carrying collided and the four displacements.
// A pair is taken at each clock edge where start is high; busy is always
// low, so a new pair may follow in every cycle.
// Pipeline: two geometry stages, one multiply stage, sixteen divider stages
// (one quotient bit each) and the output register, in that order.
// Throughput is one pair per cycle; the divider sets the depth.
// Each result stays on the ports for exactly one cycle and the receiver
// cannot hold it off.
// Synchronous reset empties the pipeline: no done strobe appears for
// pairs taken before reset.
// Depends on apcr_pkg, apcr_geom and apcr_div.
module aabb_pair_collision_resolve import apcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [PosW-1:0]  pos1_x,
  input  logic signed [PosW-1:0]  pos1_y,
  input  logic signed [PosW-1:0]  pos2_x,
  input  logic signed [PosW-1:0]  pos2_y,
  input  logic [SizeW-1:0]        size1_x,
  input  logic [SizeW-1:0]        size1_y,
  input  logic [SizeW-1:0]        size2_x,
  input  logic [SizeW-1:0]        size2_y,
  input  logic                    static1,
  input  logic                    static2,
  input  logic [MassW-1:0]        mass1,
  input  logic [MassW-1:0]        mass2,
  output logic                    done,
  output logic                    collided,
  output logic signed [MoveW-1:0] move1_x,
  output logic signed [MoveW-1:0] move1_y,
  output logic signed [MoveW-1:0] move2_x,
  output logic signed [MoveW-1:0] move2_y
);

  ctl_t             ctl_g, ctl_m, ctl_d;
  logic [MassW-1:0] m1, m2;
  logic [2*PenW-1:0] prod;
  logic [DivW-1:0]  den;
  logic [PenW-1:0]  quo;

  logic signed [MoveW-1:0] mv1, mv2, pe, se, re;
  logic [PenW-1:0]         rem_share;

  assign busy = 1'b0;

  apcr_geom u_geom (
    .clk, .rst,
    .in_valid (start),
    .pos1_x, .pos1_y, .pos2_x, .pos2_y,
    .size1_x, .size1_y, .size2_x, .size2_y,
    .static1, .static2, .mass1, .mass2,
    .ctl (ctl_g),
    .m1, .m2
  );

  // share numerator and total mass
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m.valid <= 1'b0;
    end else begin
      ctl_m.valid <= ctl_g.valid;
    end
    ctl_m.hit     <= ctl_g.hit;
    ctl_m.along_y <= ctl_g.along_y;
    ctl_m.mode    <= ctl_g.mode;
    ctl_m.neg     <= ctl_g.neg;
    ctl_m.zero    <= ctl_g.zero;
    ctl_m.p       <= ctl_g.p;
    prod <= ctl_g.p * m1;
    den  <= {1'b0, m1} + {1'b0, m2};
  end

  apcr_div u_div (
    .clk, .rst,
    .ctl_in  (ctl_m),
    .num_hi  (prod[2*PenW-1:PenW]),
    .num_lo  (prod[PenW-1:0]),
    .den,
    .ctl_out (ctl_d),
    .quo
  );

  always_comb begin
    rem_share = ctl_d.p - quo;
    pe = signed'({1'b0, ctl_d.p});
    se = signed'({1'b0, quo});
    re = signed'({1'b0, rem_share});
    mv1 = '0;
    mv2 = '0;
    case (ctl_d.mode)
      MV_BOTH: begin
        mv1 = ctl_d.neg ? re : -re;
        mv2 = ctl_d.neg ? -se : se;
      end
      MV_ONE1: mv1 = ctl_d.neg ? pe : -pe;
      MV_ONE2: mv2 = (!ctl_d.neg && !ctl_d.zero) ? pe : -pe;
      default: begin
        mv1 = '0;
        mv2 = '0;
      end
    endcase
    if (!ctl_d.hit) begin
      mv1 = '0;
      mv2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d.valid;
    end
    collided <= ctl_d.hit;
    move1_x  <= ctl_d.along_y ? '0 : mv1;
    move2_x  <= ctl_d.along_y ? '0 : mv2;
    move1_y  <= ctl_d.along_y ? mv1 : '0;
    move2_y  <= ctl_d.along_y ? mv2 : '0;
  end

endmodule

// File: design/apcr_geom.sv
// Two register stages: centre distances and half-size sums, then overlap,
// penetration and axis choice. Depends on apcr_pkg.
module apcr_geom import apcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [PosW-1:0]  pos1_x,
  input  logic signed [PosW-1:0]  pos1_y,
  input  logic signed [PosW-1:0]  pos2_x,
  input  logic signed [PosW-1:0]  pos2_y,
  input  logic [SizeW-1:0]        size1_x,
  input  logic [SizeW-1:0]        size1_y,
  input  logic [SizeW-1:0]        size2_x,
  input  logic [SizeW-1:0]        size2_y,
  input  logic                    static1,
  input  logic                    static2,
  input  logic [MassW-1:0]        mass1,
  input  logic [MassW-1:0]        mass2,
  output ctl_t                    ctl,
  output logic [MassW-1:0]        m1,
  output logic [MassW-1:0]        m2
);

  logic signed [PosW:0] dx_w, dy_w;
  logic [SizeW:0]       hx_w, hy_w;

  // stage 1
  logic             v1;
  logic             st1_1, st2_1;
  logic [PosW:0]    ax, ay;
  logic [SizeW-1:0] hx, hy;
  logic             nx, ny, zx, zy;
  logic [MassW-1:0] m1_1, m2_1;

  // stage 2 logic
  logic            ovx, ovy, ay_sel;
  logic [PenW-1:0] px, py;
  move_mode_t      mode_w;

  always_comb begin
    dx_w = {pos2_x[PosW-1], pos2_x} - {pos1_x[PosW-1], pos1_x};
    dy_w = {pos2_y[PosW-1], pos2_y} - {pos1_y[PosW-1], pos1_y};
    hx_w = {1'b0, size1_x} + {1'b0, size2_x};
    hy_w = {1'b0, size1_y} + {1'b0, size2_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    st1_1 <= static1;
    st2_1 <= static2;
    ax    <= dx_w[PosW] ? (PosW+1)'(0) - dx_w : dx_w;
    ay    <= dy_w[PosW] ? (PosW+1)'(0) - dy_w : dy_w;
    nx    <= dx_w[PosW];
    ny    <= dy_w[PosW];
    zx    <= (dx_w == '0);
    zy    <= (dy_w == '0);
    hx    <= hx_w[SizeW:1];
    hy    <= hy_w[SizeW:1];
    m1_1  <= mass1;
    m2_1  <= mass2;
  end

  always_comb begin
    ovx    = ax < {{(PosW+1-SizeW){1'b0}}, hx};
    ovy    = ay < {{(PosW+1-SizeW){1'b0}}, hy};
    px     = hx - ax[PenW-1:0];
    py     = hy - ay[PenW-1:0];
    ay_sel = px > py;
    if (!st1_1 && !st2_1) begin
      mode_w = (m1_1 != '0 && m2_1 != '0) ? MV_BOTH : MV_NONE;
    end else if (!st1_1) begin
      mode_w = MV_ONE1;
    end else begin
      mode_w = MV_ONE2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= v1;
    end
    ctl.hit     <= !(st1_1 && st2_1) && ovx && ovy;
    ctl.along_y <= ay_sel;
    ctl.mode    <= mode_w;
    ctl.neg     <= ay_sel ? ny : nx;
    ctl.zero    <= ay_sel ? zy : zx;
    ctl.p       <= ay_sel ? py : px;
    m1          <= m1_1;
    m2          <= m2_1;
  end

endmodule

// File: design/apcr_div.sv
// Restoring divider, one quotient bit per register stage, with control
// carried alongside. Depends on apcr_pkg.
module apcr_div import apcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl_in,
  input  logic [PenW-1:0]   num_hi,
  input  logic [PenW-1:0]   num_lo,
  input  logic [DivW-1:0]   den,
  output ctl_t              ctl_out,
  output logic [PenW-1:0]   quo
);

  // high half is below the divisor, so the quotient fits PenW bits
  logic [DivW-1:0] rem_s [0:PenW];
  logic [PenW-1:0] lo_s  [0:PenW];
  logic [PenW-1:0] q_s   [0:PenW];
  logic [DivW-1:0] den_s [0:PenW];
  ctl_t            ctl_s [0:PenW];

  assign rem_s[0] = {1'b0, num_hi};
  assign lo_s[0]  = num_lo;
  assign q_s[0]   = '0;
  assign den_s[0] = den;
  assign ctl_s[0] = ctl_in;

  for (genvar k = 0; k < PenW; k++) begin : g_stage
    logic [DivW:0] t;
    logic          ge;
    always_comb begin
      t  = {rem_s[k], lo_s[k][PenW-1]};
      ge = t >= {1'b0, den_s[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1].valid <= 1'b0;
      end else begin
        ctl_s[k+1].valid <= ctl_s[k].valid;
      end
      ctl_s[k+1].hit     <= ctl_s[k].hit;
      ctl_s[k+1].along_y <= ctl_s[k].along_y;
      ctl_s[k+1].mode    <= ctl_s[k].mode;
      ctl_s[k+1].neg     <= ctl_s[k].neg;
      ctl_s[k+1].zero    <= ctl_s[k].zero;
      ctl_s[k+1].p       <= ctl_s[k].p;
      rem_s[k+1] <= ge ? DivW'(t - {1'b0, den_s[k]}) : t[DivW-1:0];
      lo_s[k+1]  <= {lo_s[k][PenW-2:0], 1'b0};
      q_s[k+1]   <= {q_s[k][PenW-2:0], ge};
      den_s[k+1] <= den_s[k];
    end
  end

  assign ctl_out = ctl_s[PenW];
  assign quo     = q_s[PenW];

endmodule
